/* sv/jas_pkg.sv */
// Shared types and constants for the joystick auto-center smoother.
// No dependencies; imported by the channel interfaces and the core.
`timescale 1ns / 1ps
`default_nettype none

package jas_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int FIX_SHIFT = 8;
  localparam int ACC_W     = SAMPLE_W + FIX_SHIFT;
  localparam int CFG_IDX_W = 2;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [ACC_W-1:0]     acc_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t CFG_DEFAULT_CENTER = 2'd0;
  localparam cfg_idx_t CFG_MAX_SPREAD     = 2'd1;
  localparam cfg_idx_t CFG_CENTER_MIN     = 2'd2;
  localparam cfg_idx_t CFG_CENTER_MAX     = 2'd3;

  // Register reset values
  localparam sample_t RST_DEFAULT_CENTER = 12'd2048;
  localparam sample_t RST_MAX_SPREAD     = 12'd100;
  localparam sample_t RST_CENTER_MIN     = 12'd1200;
  localparam sample_t RST_CENTER_MAX     = 12'd2900;

  localparam sample_t SAMPLE_MAX = 12'd4095;

endpackage

`default_nettype wire

/* sv/jas_in_if.sv */
// Input channel: one raw steering sample per request.
// Depends on jas_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface jas_in_if;
  import jas_pkg::*;

  logic    valid;
  logic    ready;
  sample_t raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

`default_nettype wire

/* sv/jas_out_if.sv */
// Result channel: calibration flag, current center and smoothed value.
// Depends on jas_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface jas_out_if;
  import jas_pkg::*;

  logic    valid;
  logic    ready;
  logic    calibrated;
  sample_t center_value;
  sample_t smoothed;

  modport source (output valid, output calibrated, output center_value, output smoothed,
                  input ready);
  modport sink   (input valid, input calibrated, input center_value, input smoothed,
                  output ready);
endinterface

`default_nettype wire

/* sv/joystick_autocenter_smoother_core.sv */
// Joystick auto-center calibration with exponential smoothing.
// Each accepted sample's result is loaded into the output register in the cycle after it is accepted.
// Throughput: 1 sample per cycle unless out_ch stalls a full output register; the whole update
// (window sum, reciprocal multiply for the window mean, bound checks, filter step) is combinational.
// Reset (rst_n low, synchronous): registers to defaults, calibrating, window cleared,
// center and filter at the default center, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module joystick_autocenter_smoother_core #(
  parameter int WINDOW_LEN = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  jas_in_if.sink              in_ch,
  jas_out_if.source           out_ch,
  input  wire                 cfg_we,
  input  jas_pkg::cfg_idx_t   cfg_index,
  input  jas_pkg::sample_t    cfg_wdata
);
  import jas_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int DIV_SH = SUM_W + CNT_W;
  localparam int RCP_W  = SUM_W + 1;
  localparam int PRD_W  = SUM_W + RCP_W;
  localparam int DIF_W  = ACC_W + 1;
  // ceil(2^DIV_SH / WINDOW_LEN): exact quotient for every sum below 2^SUM_W
  localparam longint unsigned RCP_VAL =
    ((64'd1 << DIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RCP_W-1:0] RCP      = RCP_W'(RCP_VAL);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LEN - 1);

  // Configuration registers
  sample_t max_spread_r, center_min_r, center_max_r;

  // Block state
  logic             cal_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] count_r;
  sample_t          min_r, max_r;
  sample_t          center_r;
  acc_t             acc_r;

  // Output register
  logic    out_valid_r;
  logic    out_cal_r;
  sample_t out_center_r, out_smooth_r;

  logic accept;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  sample_t             raw;
  logic [SUM_W-1:0]    sum_nxt;
  sample_t             min_nxt, max_nxt;
  logic [PRD_W-1:0]    prod;
  sample_t             mean;
  logic                win_end, lock;
  acc_t                acc_base, acc_nxt;
  logic signed [DIF_W-1:0] diff, half, acc_sum;

  always_comb begin
    raw     = in_ch.raw_sample;
    sum_nxt = sum_r + SUM_W'(raw);
    min_nxt = (raw < min_r) ? raw : min_r;
    max_nxt = (raw > max_r) ? raw : max_r;
    prod    = PRD_W'(sum_nxt) * PRD_W'(RCP);
    mean    = prod[DIV_SH +: SAMPLE_W];
    win_end = cal_r && (count_r == CNT_LAST);
    lock    = win_end && ((max_nxt - min_nxt) <= max_spread_r) &&
              (mean >= center_min_r) && (mean <= center_max_r);
    acc_base = lock ? {mean, FIX_SHIFT'(0)} : acc_r;
    diff     = $signed({1'b0, raw, FIX_SHIFT'(0)}) - $signed({1'b0, acc_base});
    // halve, truncating toward zero
    half     = (diff + (diff[DIF_W-1] ? DIF_W'(1) : DIF_W'(0))) >>> 1;
    acc_sum  = $signed({1'b0, acc_base}) + half;
    acc_nxt  = acc_sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_spread_r     <= RST_MAX_SPREAD;
      center_min_r     <= RST_CENTER_MIN;
      center_max_r     <= RST_CENTER_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        // acts only on the center and filter preset below
        CFG_DEFAULT_CENTER: ;
        CFG_MAX_SPREAD:     max_spread_r     <= cfg_wdata;
        CFG_CENTER_MIN:     center_min_r     <= cfg_wdata;
        CFG_CENTER_MAX:     center_max_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r    <= 1'b1;
      sum_r    <= '0;
      count_r  <= '0;
      min_r    <= SAMPLE_MAX;
      max_r    <= '0;
      center_r <= RST_DEFAULT_CENTER;
      acc_r    <= {RST_DEFAULT_CENTER, FIX_SHIFT'(0)};
    end else if (accept) begin
      acc_r <= acc_nxt;
      if (cal_r) begin
        if (win_end) begin
          sum_r   <= '0;
          count_r <= '0;
          min_r   <= SAMPLE_MAX;
          max_r   <= '0;
        end else begin
          sum_r   <= sum_nxt;
          count_r <= count_r + CNT_W'(1);
          min_r   <= min_nxt;
          max_r   <= max_nxt;
        end
      end
      if (lock) begin
        cal_r    <= 1'b0;
        center_r <= mean;
      end
    end else if (cfg_we && (cfg_index == CFG_DEFAULT_CENTER) && cal_r) begin
      // preset center and filter while still calibrating
      center_r <= cfg_wdata;
      acc_r    <= {cfg_wdata, FIX_SHIFT'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_cal_r    <= !cal_r || lock;
      out_center_r <= lock ? mean : center_r;
      out_smooth_r <= acc_nxt[ACC_W-1 -: SAMPLE_W];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.calibrated   = out_cal_r;
  assign out_ch.center_value = out_center_r;
  assign out_ch.smoothed     = out_smooth_r;

endmodule

`default_nettype wire
